// ===== design/tle_pkg.sv =====
// Shared types, character codes and output sequence tables for the terminal line editor.
package tle_pkg;

  localparam int unsigned LINE_BYTES  = 256;
  localparam int unsigned ADDR_W      = $clog2(LINE_BYTES);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] term_byte;
    logic       term_valid;
    logic       line_ready;
    logic [7:0] line_length;
    logic [7:0] read_data;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    JOB_ECHO,
    JOB_ERASE,
    JOB_EOL,
    JOB_CANCEL,
    JOB_READ
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] data;
    logic [7:0] len;
    logic       nonempty;
  } job_t;

  // Index of the final beat of each job.
  function automatic logic [2:0] job_last(input job_kind_e kind);
    logic [2:0] r;
    case (kind)
      JOB_ECHO:   r = 3'd0;
      JOB_ERASE:  r = 3'd2;
      JOB_EOL:    r = 3'd5;
      JOB_CANCEL: r = 3'd7;
      JOB_READ:   r = 3'd0;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] prompt_byte(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = CH_P;
      2'd1:    r = CH_M;
      2'd2:    r = CH_GT;
      default: r = CH_SPACE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] job_byte(input job_kind_e kind, input logic [2:0] step,
                                          input logic [7:0] data);
    logic [7:0] r;
    case (kind)
      JOB_ECHO:  r = data;
      JOB_ERASE: r = (step == 3'd1) ? CH_SPACE : CH_BS;
      JOB_EOL: begin
        case (step)
          3'd0:    r = CH_CR;
          3'd1:    r = CH_LF;
          default: r = prompt_byte(2'(step - 3'd2));
        endcase
      end
      JOB_CANCEL: begin
        case (step)
          3'd0:    r = CH_CARET;
          3'd1:    r = CH_UC_C;
          3'd2:    r = CH_CR;
          3'd3:    r = CH_LF;
          default: r = prompt_byte(step[1:0]);
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== design/tle_front.sv =====
// Front end: classifies received bytes, keeps the fill position and line store, issues jobs.
module tle_front import tle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);

  logic [7:0]        line_store [LINE_BYTES];
  logic [7:0]        rdata_q;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              s_valid_q, s_valid_d;
  job_t              s_job_q, job_d;
  logic              s_inrange_q;
  logic              s_free, in_fire, has_res, wr_en, rd_en;
  logic [31:0]       idx_ext, pos_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic              in_range;

  assign s_free     = !s_valid_q || job_ready_i;
  assign in_ready_o = s_free;
  assign in_fire    = in_valid_i && s_free;

  assign idx_ext  = 32'(in_data_i.read_index);
  assign pos_ext  = 32'(pos_q);
  assign rd_addr  = idx_ext[ADDR_W-1:0];
  assign in_range = idx_ext < 32'(LINE_BYTES);

  always_comb begin
    job_d          = s_job_q;
    job_d.kind     = JOB_ECHO;
    job_d.data     = in_data_i.rx_byte;
    job_d.len      = 8'h00;
    job_d.nonempty = 1'b0;
    has_res        = 1'b0;
    pos_d          = pos_q;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    if (in_fire) begin
      if (in_data_i.cmd == CMD_READ) begin
        job_d.kind = JOB_READ;
        has_res    = 1'b1;
        rd_en      = 1'b1;
      end else begin
        case (in_data_i.rx_byte) inside
          CH_CR, CH_LF: begin
            job_d.kind     = JOB_EOL;
            job_d.len      = pos_ext[7:0];
            job_d.nonempty = (pos_q != '0);
            pos_d          = '0;
            has_res        = 1'b1;
          end
          CH_BS, CH_DEL: begin
            if (pos_q != '0) begin
              job_d.kind = JOB_ERASE;
              pos_d      = pos_q - 1'b1;
              has_res    = 1'b1;
            end
          end
          [CH_SPACE:CH_TILDE]: begin
            if (pos_q != ADDR_W'(LINE_BYTES - 1)) begin
              job_d.kind = JOB_ECHO;
              wr_en      = 1'b1;
              pos_d      = pos_q + 1'b1;
              has_res    = 1'b1;
            end
          end
          CH_ETX: begin
            job_d.kind = JOB_CANCEL;
            pos_d      = '0;
            has_res    = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    s_valid_d = s_valid_q;
    if (s_free) begin
      s_valid_d = in_fire && has_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      s_valid_q <= s_valid_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_job_q     <= job_d;
      s_inrange_q <= in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_store[pos_q] <= in_data_i.rx_byte;
    end
    if (rd_en) begin
      rdata_q <= line_store[rd_addr];
    end
  end

  always_comb begin
    job_o = s_job_q;
    if (s_job_q.kind == JOB_READ) begin
      job_o.data = s_inrange_q ? rdata_q : 8'h00;
    end
  end

  assign job_valid_o = s_valid_q;

endmodule

// ===== design/tle_queue.sv =====
// Short job queue between the front end and the output sequencer.
module tle_queue import tle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic head_valid_o,
  input  logic pop_i,
  output job_t head_job_o
);

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q, count_d;
  logic                push, pop;

  assign push_ready_o = count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign head_valid_o = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;
  assign head_job_o   = entries[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== design/tle_back.sv =====
// Output sequencer: expands each job into its result beats through an output register.
module tle_back import tle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic       out_valid_q;
  out_item_t  out_q, out_d;
  logic [2:0] step_q;
  logic       load, is_last, is_read, is_lf;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = step_q == job_last(head_job_i.kind);
  assign is_read = head_job_i.kind == JOB_READ;
  assign is_lf   = (head_job_i.kind == JOB_EOL) && (step_q == 3'd1) && head_job_i.nonempty;
  assign pop_o   = load && is_last;

  always_comb begin
    out_d.term_byte   = job_byte(head_job_i.kind, step_q, head_job_i.data);
    out_d.term_valid  = !is_read;
    out_d.line_ready  = is_lf;
    out_d.line_length = is_lf ? head_job_i.len : 8'h00;
    out_d.read_data   = is_read ? head_job_i.data : 8'h00;
    out_d.last        = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        step_q      <= is_last ? 3'd0 : step_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/terminal_line_editor.sv =====
// Top level of the terminal line editor: front end, job queue and output sequencer.
// Received bytes enter at up to one per cycle while the front-end stage is free or the
// two-entry job queue has room; an ignored or dropped item leaves no trace at the output.
// Each accepted item that produces output becomes one job, and the output sequencer sends
// one beat per cycle while the receiver is ready: 1 beat for an echo or a read, 3 for an
// erase, 6 for end of line, 8 for Ctrl-C. The first beat passes through the front-end
// stage register, job queue and output register; reads see all bytes earlier items wrote.
module terminal_line_editor import tle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic job_valid, job_ready, head_valid, pop;
  job_t job, head_job;

  tle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  tle_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_job_i   (job),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_job_o   (head_job)
  );

  tle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== bench/terminal_line_editor_test.sv =====
// Self-checking testbench for terminal_line_editor: directed and random byte streams.
module terminal_line_editor_test import tle_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 4000;

  class terminal_echo_board;
    out_item_t   echo_due[$];
    logic [7:0]  line_buf[LINE_BYTES];
    int unsigned fill;
    int unsigned high_water;
    int unsigned mismatches;

    function void push_term(logic [7:0] b, logic rdy, logic [7:0] len);
      out_item_t r;
      r = '0;
      r.term_byte   = b;
      r.term_valid  = 1'b1;
      r.line_ready  = rdy;
      r.line_length = len;
      echo_due.push_back(r);
    endfunction

    function void push_prompt();
      push_term(CH_P, 1'b0, 8'd0);
      push_term(CH_M, 1'b0, 8'd0);
      push_term(CH_GT, 1'b0, 8'd0);
      push_term(CH_SPACE, 1'b0, 8'd0);
    endfunction

    // Returns the number of beats this item is due to produce.
    function int take_item(in_item_t it);
      int         n0;
      out_item_t  r;
      logic [7:0] c;
      n0 = echo_due.size();
      c  = it.rx_byte;
      if (it.cmd == CMD_READ) begin
        r = '0;
        r.read_data = line_buf[it.read_index];
        echo_due.push_back(r);
      end else if (c == CH_CR || c == CH_LF) begin
        push_term(CH_CR, 1'b0, 8'd0);
        push_term(CH_LF, fill != 0, 8'(fill));
        fill = 0;
        push_prompt();
      end else if (c == CH_BS || c == CH_DEL) begin
        if (fill != 0) begin
          fill--;
          push_term(CH_BS, 1'b0, 8'd0);
          push_term(CH_SPACE, 1'b0, 8'd0);
          push_term(CH_BS, 1'b0, 8'd0);
        end
      end else if (c >= CH_SPACE && c <= CH_TILDE) begin
        if (fill < LINE_BYTES - 1) begin
          line_buf[fill] = c;
          fill++;
          if (fill > high_water) high_water = fill;
          push_term(c, 1'b0, 8'd0);
        end
      end else if (c == CH_ETX) begin
        push_term(CH_CARET, 1'b0, 8'd0);
        push_term(CH_UC_C, 1'b0, 8'd0);
        push_term(CH_CR, 1'b0, 8'd0);
        push_term(CH_LF, 1'b0, 8'd0);
        fill = 0;
        push_prompt();
      end
      if (echo_due.size() > n0) begin
        r = echo_due.pop_back();
        r.last = 1'b1;
        echo_due.push_back(r);
      end
      return echo_due.size() - n0;
    endfunction

    function void match_beat(out_item_t got);
      out_item_t want;
      if (echo_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat %h at %0t", got, $realtime);
        return;
      end
      want = echo_due.pop_front();
      if (got.term_byte !== want.term_byte || got.term_valid !== want.term_valid ||
          got.line_ready !== want.line_ready || got.line_length !== want.line_length ||
          got.read_data !== want.read_data || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at %0t (want/got): term_byte %h/%h term_valid %b/%b ",
                    "line_ready %b/%b line_length %0d/%0d read_data %h/%h last %b/%b"},
                   $realtime, want.term_byte, got.term_byte, want.term_valid,
                   got.term_valid, want.line_ready, got.line_ready, want.line_length,
                   got.line_length, want.read_data, got.read_data, want.last, got.last);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  terminal_echo_board board;
  bit          calm;
  int unsigned sent;
  int unsigned quiet_cycles;
  int unsigned stall_left;

  terminal_line_editor uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver side: ready drops in bursts of random length.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.match_beat(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send(in_item_t it);
    if (!calm && $urandom_range(0, 9) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    void'(board.take_item(it));
    sent++;
  endtask

  task automatic send_rx(logic [7:0] c);
    in_item_t it;
    it.cmd        = CMD_RX;
    it.rx_byte    = c;
    it.read_index = 8'($urandom);
    send(it);
  endtask

  task automatic send_read(logic [7:0] idx);
    in_item_t it;
    it.cmd        = CMD_READ;
    it.rx_byte    = 8'($urandom);
    it.read_index = idx;
    send(it);
  endtask

  task automatic read_some();
    if (board.high_water > 0) send_read(8'($urandom_range(0, board.high_water - 1)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.echo_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int  n;
    int  pick;
    bit  long_done;
    board      = new;
    calm       = 1'b0;
    sent       = 0;
    long_done  = 1'b0;
    quiet_cycles = 0;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty-line ends, erase on empty, ignored controls, edges of printable range
    send_rx(CH_CR);
    send_rx(CH_LF);
    send_rx(CH_BS);
    send_rx(CH_DEL);
    send_rx(8'h09);
    send_rx(8'h1B);
    send_rx(8'h00);
    send_rx(8'h80);
    send_rx(8'hFF);
    send_rx(8'h1F);
    send_rx(CH_SPACE);
    send_rx(CH_TILDE);
    send_rx(8'h41);
    send_read(8'd0);
    send_read(8'd2);
    send_rx(CH_BS);
    send_rx(CH_DEL);
    send_rx(CH_CR);
    send_rx(8'h78);
    send_rx(CH_CR);
    send_rx(CH_LF);
    send_rx(8'h61);
    send_rx(8'h62);
    send_rx(CH_ETX);
    send_read(8'd1);
    drain();

    while (sent < 400) begin
      if (sent >= 340) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (!long_done && sent >= 60) begin
        // fill the store past capacity, erase while full, then read back
        long_done = 1'b1;
        repeat (LINE_BYTES + 3) send_rx(8'($urandom_range(32, 126)));
        send_rx(CH_DEL);
        send_rx(8'($urandom_range(32, 126)));
        send_rx(8'($urandom_range(32, 126)));
        send_read(8'(LINE_BYTES - 2));
        repeat (6) read_some();
        send_rx(CH_CR);
      end else if (pick < 75) begin
        n = $urandom_range(0, 24);
        repeat (n) begin
          pick = $urandom_range(0, 99);
          if (pick < 72) send_rx(8'($urandom_range(32, 126)));
          else if (pick < 86) send_rx(pick[0] ? CH_BS : CH_DEL);
          else if (pick < 95) read_some();
          else send_rx(8'($urandom));
        end
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2: send_rx(CH_CR);
          3, 4:    send_rx(CH_LF);
          5, 6: begin
            send_rx(CH_CR);
            send_rx(CH_LF);
          end
          7:       send_rx(CH_ETX);
          default: ;
        endcase
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) read_some();
          else send_rx(8'($urandom));
        end
      end else begin
        drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.echo_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
